@@ rtl/timed_lease_slot_pool_top_macros.svh @@
// ----------------------------------------------------------------------------
// Timed lease slot pool assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TIMED_LEASE_SLOT_POOL_TOP_MACROS_SVH
`define TIMED_LEASE_SLOT_POOL_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TLSP_ASSERT_IMPLY(label, a_clk, a_rst_n, ante, cons, msg) \
  label: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TLSP_ASSERT_NEXT(label, a_clk, a_rst_n, ante, cons, msg) \
  label: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tlsp_pkg.sv @@
// ----------------------------------------------------------------------------
// Timed lease slot pool package
// Field widths, operation and status codes and the controller state type.
// ----------------------------------------------------------------------------
package tlsp_pkg;

  localparam int ID_W        = 64;
  localparam int CD_W        = 16;
  localparam int STATUS_W    = 3;
  localparam int IDX_OUT_W   = 4;
  localparam int ENTRY_W     = ID_W + CD_W;

  localparam logic [CD_W-1:0] LEASE_RESET = 16'd16;

  localparam logic OP_TICK     = 1'b0;
  localparam logic OP_RETRIEVE = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_HIT    = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_CLAIM  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_REJECT = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_TICK   = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

endpackage

@@ rtl/timed_lease_slot_pool_top.sv @@
// Flow: an accepted transaction goes from ST_IDLE through ST_SCAN to ST_FIN, where the result
// is registered; a retrieve with id zero skips the scan and goes straight to ST_FIN.
// in_stall holds off a new transaction until the block is back in ST_IDLE. The scan reads the
// slot memory through its single read port, one slot per cycle; a stalled result delays.
// Reset: synchronous, active low; the slot table reads as all free through per-slot
// valid bits, so no clearing pass is needed, and lease_ticks returns to 16.
// ----------------------------------------------------------------------------
// Timed lease slot pool
// Slot table of owner ids and lease countdowns kept in one synchronous memory,
// scanned read-modify-write for renew, claim and aging.
// ----------------------------------------------------------------------------
`include "timed_lease_slot_pool_top_macros.svh"

module timed_lease_slot_pool_top #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [tlsp_pkg::ID_W-1:0]     in_owner_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tlsp_pkg::STATUS_W-1:0] out_status,
  output logic [tlsp_pkg::IDX_OUT_W-1:0] out_slot_index,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tlsp_pkg::CD_W-1:0]     cfg_lease_ticks
);
  import tlsp_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SLOT_COUNT);

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r;
  logic                    op_r;
  logic [ID_W-1:0]         id_r;
  logic [CD_W-1:0]         lease_r;
  logic [SLOT_COUNT-1:0]   vld_r;
  logic [ENTRY_W-1:0]      mem [SLOT_COUNT];
  logic [ENTRY_W-1:0]      rd_data_r;
  logic                    rd_vld_r;
  logic [IDX_W-1:0]        rd_idx_r;
  logic                    hit_r, free_r;
  logic [IDX_W-1:0]        hit_idx_r, free_idx_r;
  logic                    out_valid_r;
  logic [STATUS_W-1:0]     out_status_r;
  logic [IDX_OUT_W-1:0]    out_slot_index_r;

  logic                    in_accept;
  logic [IDX_W-1:0]        rd_addr;
  logic                    proc_en;
  logic [ID_W-1:0]         cur_owner;
  logic [CD_W-1:0]         cur_cd;
  logic [CD_W-1:0]         dec_cd;
  logic                    cur_live;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  logic [ENTRY_W-1:0]      mem_wdata;
  logic                    fin_done;
  logic [STATUS_W-1:0]     fin_status;
  logic [IDX_W-1:0]        fin_idx;
  logic [IDX_W+IDX_OUT_W-1:0] fin_idx_ext;

  assign in_stall       = (state_r != ST_IDLE);
  assign in_accept      = in_valid && !in_stall;
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_index = out_slot_index_r;

  // Entry data arriving from memory; an entry never written reads as free.
  assign proc_en   = (state_r == ST_SCAN) && (cnt_r != '0);
  assign cur_owner = rd_vld_r ? rd_data_r[ENTRY_W-1:CD_W] : '0;
  assign cur_cd    = rd_vld_r ? rd_data_r[CD_W-1:0] : '0;
  assign cur_live  = (cur_owner != '0) && (cur_cd != '0);
  assign dec_cd    = cur_cd - CD_W'(1);
  assign rd_addr   = (cnt_r < CNT_LAST) ? cnt_r[IDX_W-1:0] : '0;

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if ((in_operation == OP_RETRIEVE) && (in_owner_id == '0)) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output and memory control logic
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = rd_idx_r;
    mem_wdata  = {cur_owner, cur_cd};
    fin_done   = 1'b0;
    fin_status = STAT_TICK;
    fin_idx    = '0;
    if (op_r == OP_RETRIEVE) begin
      if (id_r == '0) begin
        fin_status = STAT_REJECT;
      end else if (hit_r) begin
        fin_status = STAT_HIT;
        fin_idx    = hit_idx_r;
      end else if (free_r) begin
        fin_status = STAT_CLAIM;
        fin_idx    = free_idx_r;
      end else begin
        fin_status = STAT_FULL;
      end
    end
    case (state_r)
      ST_SCAN: begin
        // A tick ages each live slot as its data returns and frees it at zero.
        if (proc_en && (op_r == OP_TICK) && cur_live) begin
          mem_we    = 1'b1;
          mem_waddr = rd_idx_r;
          mem_wdata = {((dec_cd == '0) ? {ID_W{1'b0}} : cur_owner), dec_cd};
        end
      end
      ST_FIN: begin
        fin_done = !out_valid_r || !out_stall;
        if (fin_done && ((fin_status == STAT_HIT) || (fin_status == STAT_CLAIM))) begin
          mem_we    = 1'b1;
          mem_waddr = fin_idx;
          mem_wdata = {id_r, lease_r};
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign fin_idx_ext = {{IDX_OUT_W{1'b0}}, fin_idx};

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
    rd_idx_r  <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      lease_r     <= LEASE_RESET;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      cnt_r       <= '0;
      op_r        <= OP_TICK;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= vld_r[rd_addr];
      if (mem_we) begin
        vld_r[mem_waddr] <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        lease_r <= cfg_lease_ticks;
      end
      if (fin_done) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_accept) begin
        cnt_r  <= '0;
        op_r   <= in_operation;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else if (state_r == ST_SCAN) begin
        cnt_r <= cnt_r + CNT_W'(1);
        // Keep the first live match and the lowest free slot.
        if (proc_en && (op_r == OP_RETRIEVE)) begin
          if (cur_live && (cur_owner == id_r) && !hit_r) begin
            hit_r <= 1'b1;
          end
          if (!cur_live && !free_r) begin
            free_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      id_r <= in_owner_id;
    end
    if (proc_en && (op_r == OP_RETRIEVE)) begin
      if (cur_live && (cur_owner == id_r) && !hit_r) begin
        hit_idx_r <= rd_idx_r;
      end
      if (!cur_live && !free_r) begin
        free_idx_r <= rd_idx_r;
      end
    end
    if (fin_done) begin
      out_status_r     <= fin_status;
      out_slot_index_r <= fin_idx_ext[IDX_OUT_W-1:0];
    end
  end

  `TLSP_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_accept, state_r != ST_IDLE,
                    "Accepted transaction did not start work")
  `TLSP_ASSERT_IMPLY(a_write_when_busy, clk, rst_n, mem_we,
                     (state_r == ST_SCAN) || (state_r == ST_FIN),
                     "Slot memory written while idle")
  `TLSP_ASSERT_NEXT(a_fin_gives_result, clk, rst_n, fin_done, out_valid_r,
                    "Finished item produced no result")
  `TLSP_ASSERT_IMPLY(a_index_zero, clk, rst_n,
                     out_valid_r && (out_status_r != STAT_HIT) && (out_status_r != STAT_CLAIM),
                     out_slot_index_r == '0, "Slot index nonzero without a hit or claim")

endmodule
